// ===== hw/rtl/virtual_spring_damper_force_macros.svh =====
// Assertion macros for the virtual spring-damper force block.
// Needs signals named clk and rst_n in the scope where a macro is used.
`ifndef VIRTUAL_SPRING_DAMPER_FORCE_MACROS_SVH
`define VIRTUAL_SPRING_DAMPER_FORCE_MACROS_SVH

// Plain property, checked on every clock edge out of reset.
`define VSDF_ASSERT(label, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Same-cycle implication.
`define VSDF_ASSERT_IMP(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication.
`define VSDF_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== hw/rtl/vsdf_pkg.sv =====
// Shared types, constants and fixed-point helpers for the spring-damper block.
// No dependencies; used by every module of the block.
package vsdf_pkg;

    localparam int MAX_ROBOTS_DEF = 16;

    localparam int IDX_W   = 4;
    localparam int VAL_W   = 32;
    localparam int TDATA_W = 136;
    localparam int ENTRY_W = 4 * VAL_W;

    // Configuration register indexes
    localparam int CFG_IDX_W = 2;
    localparam logic [CFG_IDX_W-1:0] REG_SPRING_GAIN = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_DAMPER_GAIN = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_SAMPLE_RATE = 2'd2;

    localparam logic [VAL_W-1:0] SPRING_GAIN_RST = 32'd65536;
    localparam logic [VAL_W-1:0] DAMPER_GAIN_RST = 32'd65536;
    localparam logic [VAL_W-1:0] SAMPLE_RATE_RST = 32'd1310720;

    // Multiplier schedule: one product issued per step; STEP_DONE issues none
    localparam int STEP_W = 4;
    localparam logic [STEP_W-1:0] STEP_RATE_X   = 4'd0;
    localparam logic [STEP_W-1:0] STEP_RATE_Y   = 4'd1;
    localparam logic [STEP_W-1:0] STEP_SPRING_X = 4'd2;
    localparam logic [STEP_W-1:0] STEP_SPRING_Y = 4'd3;
    localparam logic [STEP_W-1:0] STEP_DAMP_X   = 4'd4;
    localparam logic [STEP_W-1:0] STEP_DAMP_Y   = 4'd5;
    localparam logic [STEP_W-1:0] STEP_SQ_X     = 4'd6;
    localparam logic [STEP_W-1:0] STEP_SQ_Y     = 4'd7;
    localparam logic [STEP_W-1:0] STEP_ENLO_X   = 4'd8;
    localparam logic [STEP_W-1:0] STEP_ENHI_X   = 4'd9;
    localparam logic [STEP_W-1:0] STEP_ENLO_Y   = 4'd10;
    localparam logic [STEP_W-1:0] STEP_ENHI_Y   = 4'd11;
    localparam logic [STEP_W-1:0] STEP_DONE     = 4'd12;

    typedef struct packed {
        logic              load;
        logic              stretch;
        logic              prep;
        logic              diff;
        logic              mul;
        logic [STEP_W-1:0] step;
        logic              store;
        logic              out_load;
    } vsdf_cmd_t;

    // Magnitude of a signed word; the most negative value maps to 2^31.
    function automatic logic [VAL_W-1:0] abs32(input logic [VAL_W-1:0] v);
        abs32 = v[VAL_W-1] ? (~v + 32'd1) : v;
    endfunction

    // |offset| - |rest|, clamped at the positive limit.
    function automatic logic [VAL_W-1:0] stretch_of(input logic [VAL_W-1:0] o,
                                                   input logic [VAL_W-1:0] r);
        logic [VAL_W:0] d;
        d = {1'b0, abs32(o)} - {1'b0, abs32(r)};
        if (!d[VAL_W] && d[VAL_W-1])
            stretch_of = 32'h7FFF_FFFF;
        else
            stretch_of = d[VAL_W-1:0];
    endfunction

    // Signed rate from magnitude and sign, saturated to 32 bits.
    function automatic logic [VAL_W-1:0] rate_sat(input logic [47:0] m, input logic neg);
        if (neg)
            rate_sat = (m >= 48'h8000_0000) ? 32'h8000_0000 : (~m[VAL_W-1:0] + 32'd1);
        else
            rate_sat = (m > 48'h7FFF_FFFF) ? 32'h7FFF_FFFF : m[VAL_W-1:0];
    endfunction

    // Magnitude of the saturated rate.
    function automatic logic [VAL_W-1:0] rate_mag(input logic [47:0] m, input logic neg);
        if (neg)
            rate_mag = (m >= 48'h8000_0000) ? 32'h8000_0000 : m[VAL_W-1:0];
        else
            rate_mag = (m > 48'h7FFF_FFFF) ? 32'h7FFF_FFFF : m[VAL_W-1:0];
    endfunction

    // Apply the sign of the offset to the force sum and saturate; a zero offset gives zero.
    function automatic logic [VAL_W-1:0] force_sat(input logic signed [49:0] sum,
                                                  input logic [VAL_W-1:0] o);
        logic signed [50:0] v;
        v = o[VAL_W-1] ? -$signed({sum[49], sum}) : $signed({sum[49], sum});
        if (o == '0)
            force_sat = '0;
        else if (v > 51'sh7FFF_FFFF)
            force_sat = 32'h7FFF_FFFF;
        else if (v < -51'sh8000_0000)
            force_sat = 32'h8000_0000;
        else
            force_sat = v[VAL_W-1:0];
    endfunction

    // Energy word from the high part of K*e^2: drop 17 more bits, saturate.
    function automatic logic [VAL_W-1:0] energy_sat(input logic [63:0] hi);
        energy_sat = (hi[63:49] != '0) ? 32'hFFFF_FFFF : hi[48:17];
    endfunction

endpackage

// ===== hw/rtl/vsdf_mul.sv =====
// Shared 32x32 unsigned multiplier with a registered product.
// Depends on vsdf_pkg for widths.
module vsdf_mul import vsdf_pkg::*;
(
    input  logic               clk,
    input  logic               en,
    input  logic [VAL_W-1:0]   a,
    input  logic [VAL_W-1:0]   b,
    output logic [2*VAL_W-1:0] prod
);

    logic [2*VAL_W-1:0] prod_reg;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            prod_reg <= a * b;
        end
    end

    assign prod = prod_reg;

endmodule

// ===== hw/rtl/vsdf_ctrl.sv =====
// Sequencer for the spring-damper block: handshakes and multiplier schedule.
// Depends on vsdf_pkg for the command struct and step codes.
module vsdf_ctrl import vsdf_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      s_tvalid,
    output logic      s_tready,
    output logic      m_tvalid,
    input  logic      m_tready,
    output vsdf_cmd_t cmd
);

    localparam logic [2:0] ST_IDLE    = 3'd0;
    localparam logic [2:0] ST_STRETCH = 3'd1;
    localparam logic [2:0] ST_PREP    = 3'd2;
    localparam logic [2:0] ST_DIFF    = 3'd3;
    localparam logic [2:0] ST_MUL     = 3'd4;
    localparam logic [2:0] ST_WRITE   = 3'd5;

    logic [2:0]        state_reg, state_next;
    logic [STEP_W-1:0] step_reg, step_next;
    logic              out_valid_reg, out_valid_next;

    always_comb
    begin
        state_next     = state_reg;
        step_next      = step_reg;
        cmd            = '0;
        cmd.step       = step_reg;
        s_tready       = 1'b0;
        case (state_reg)
            ST_IDLE:
            begin
                s_tready = 1'b1;
                if (s_tvalid)
                begin
                    cmd.load   = 1'b1;
                    state_next = ST_STRETCH;
                end
            end
            ST_STRETCH:
            begin
                cmd.stretch = 1'b1;
                state_next  = ST_PREP;
            end
            ST_PREP:
            begin
                cmd.prep   = 1'b1;
                state_next = ST_DIFF;
            end
            ST_DIFF:
            begin
                cmd.diff   = 1'b1;
                step_next  = STEP_RATE_X;
                state_next = ST_MUL;
            end
            ST_MUL:
            begin
                cmd.mul = 1'b1;
                if (step_reg == STEP_DONE)
                    state_next = ST_WRITE;
                else
                    step_next = step_reg + 4'd1;
            end
            ST_WRITE:
            begin
                // hold here while the previous word is still unclaimed
                cmd.store = 1'b1;
                if (!out_valid_reg || m_tready)
                begin
                    cmd.out_load = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (cmd.out_load)
            out_valid_next = 1'b1;
        else if (m_tready)
            out_valid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            step_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            step_reg      <= step_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign m_tvalid = out_valid_reg;

endmodule

// ===== hw/rtl/vsdf_dpath.sv =====
// Datapath: configuration registers, per-robot state memory, stretch and
// rate arithmetic, shared multiplier and result register. Uses vsdf_pkg, vsdf_mul.
module vsdf_dpath import vsdf_pkg::*;
#(
    parameter int MAX_ROBOTS = MAX_ROBOTS_DEF
)
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  vsdf_cmd_t            cmd,
    input  logic                 cfg_valid,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [VAL_W-1:0]     cfg_data,
    input  logic [IDX_W-1:0]     robot_index,
    input  logic [VAL_W-1:0]     offset_x,
    input  logic [VAL_W-1:0]     offset_y,
    input  logic [VAL_W-1:0]     rest_x,
    input  logic [VAL_W-1:0]     rest_y,
    output logic [IDX_W-1:0]     robot_echo,
    output logic [VAL_W-1:0]     force_x,
    output logic [VAL_W-1:0]     force_y,
    output logic [VAL_W-1:0]     energy_x,
    output logic [VAL_W-1:0]     energy_y
);

    localparam int AW = (MAX_ROBOTS > 1) ? $clog2(MAX_ROBOTS) : 1;

    // configuration
    logic [VAL_W-1:0] spring_gain_reg, damper_gain_reg, sample_rate_reg;

    // per-robot state: {rate_y, rate_x, stretch_y, stretch_x}
    logic [ENTRY_W-1:0]    mem [0:MAX_ROBOTS-1];
    logic [MAX_ROBOTS-1:0] valid_reg;
    logic [ENTRY_W-1:0]    mem_q_reg;
    logic                  hit_reg;

    // item registers
    logic [IDX_W-1:0]  idx_reg;
    logic [AW-1:0]     addr_reg;
    logic              in_range_reg;
    logic [VAL_W-1:0]  ox_reg, oy_reg, rx_reg, ry_reg;
    logic [VAL_W-1:0]  ex_reg, ey_reg;
    logic [VAL_W-1:0]  aex_reg, aey_reg, apx_reg, apy_reg;
    logic              upd_reg;
    logic              dneg_x_reg, dneg_y_reg;
    logic [VAL_W-1:0]  dmag_x_reg, dmag_y_reg;
    logic [VAL_W-1:0]  rate_x_reg, rate_y_reg;
    logic [VAL_W-1:0]  rmag_x_reg, rmag_y_reg;
    logic signed [48:0] spring_x_reg, spring_y_reg, damp_x_reg, damp_y_reg;
    logic signed [49:0] sum_x_reg, sum_y_reg;
    logic [VAL_W-1:0]  force_x_reg, force_y_reg;
    logic [63:0]       sq_x_reg, sq_y_reg, lo_reg, hi_x_reg, hi_y_reg;

    // result register
    logic [IDX_W-1:0]  out_idx_reg;
    logic [VAL_W-1:0]  out_fx_reg, out_fy_reg, out_ex_reg, out_ey_reg;

    // multiplier
    logic              mul_en;
    logic [VAL_W-1:0]  mul_a, mul_b;
    logic [63:0]       prod;
    logic [47:0]       prod_q16;
    logic [VAL_W:0]    dx, dy;
    logic [VAL_W-1:0]  px, py;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            spring_gain_reg <= SPRING_GAIN_RST;
            damper_gain_reg <= DAMPER_GAIN_RST;
            sample_rate_reg <= SAMPLE_RATE_RST;
        end
        else if (cfg_valid)
        begin
            case (cfg_index)
                REG_SPRING_GAIN: spring_gain_reg <= cfg_data;
                REG_DAMPER_GAIN: damper_gain_reg <= cfg_data;
                REG_SAMPLE_RATE: sample_rate_reg <= cfg_data;
                default:         ;
            endcase
        end
    end

    // entries never written read as zero
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= '0;
        else if (cmd.store && in_range_reg)
            valid_reg[addr_reg] <= 1'b1;
    end

    always_ff @(posedge clk)
    begin
        if (cmd.store && in_range_reg)
            mem[addr_reg] <= {rate_y_reg, rate_x_reg, ey_reg, ex_reg};
        if (cmd.stretch)
            mem_q_reg <= mem[addr_reg];
    end

    always_comb
    begin
        mul_a = '0;
        mul_b = '0;
        case (cmd.step)
            STEP_RATE_X:   begin mul_a = dmag_x_reg;      mul_b = sample_rate_reg; end
            STEP_RATE_Y:   begin mul_a = dmag_y_reg;      mul_b = sample_rate_reg; end
            STEP_SPRING_X: begin mul_a = aex_reg;         mul_b = spring_gain_reg; end
            STEP_SPRING_Y: begin mul_a = aey_reg;         mul_b = spring_gain_reg; end
            STEP_DAMP_X:   begin mul_a = rmag_x_reg;      mul_b = damper_gain_reg; end
            STEP_DAMP_Y:   begin mul_a = rmag_y_reg;      mul_b = damper_gain_reg; end
            STEP_SQ_X:     begin mul_a = aex_reg;         mul_b = aex_reg;         end
            STEP_SQ_Y:     begin mul_a = aey_reg;         mul_b = aey_reg;         end
            STEP_ENLO_X:   begin mul_a = spring_gain_reg; mul_b = sq_x_reg[31:0];  end
            STEP_ENHI_X:   begin mul_a = spring_gain_reg; mul_b = sq_x_reg[63:32]; end
            STEP_ENLO_Y:   begin mul_a = spring_gain_reg; mul_b = sq_y_reg[31:0];  end
            STEP_ENHI_Y:   begin mul_a = spring_gain_reg; mul_b = sq_y_reg[63:32]; end
            default:       begin mul_a = '0;              mul_b = '0;              end
        endcase
    end

    assign mul_en = cmd.mul && (cmd.step != STEP_DONE);

    vsdf_mul u_mul
    (
        .clk  (clk),
        .en   (mul_en),
        .a    (mul_a),
        .b    (mul_b),
        .prod (prod)
    );

    assign prod_q16 = prod[63:16];

    assign px = hit_reg ? mem_q_reg[31:0]  : '0;
    assign py = hit_reg ? mem_q_reg[63:32] : '0;
    assign dx = {1'b0, aex_reg} - {1'b0, apx_reg};
    assign dy = {1'b0, aey_reg} - {1'b0, apy_reg};

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            idx_reg      <= robot_index;
            addr_reg     <= AW'(robot_index);
            in_range_reg <= (32'(robot_index) < MAX_ROBOTS);
            ox_reg       <= offset_x;
            oy_reg       <= offset_y;
            rx_reg       <= rest_x;
            ry_reg       <= rest_y;
        end

        if (cmd.stretch)
        begin
            ex_reg  <= stretch_of(ox_reg, rx_reg);
            ey_reg  <= stretch_of(oy_reg, ry_reg);
            hit_reg <= in_range_reg && valid_reg[addr_reg];
        end

        if (cmd.prep)
        begin
            aex_reg    <= abs32(ex_reg);
            aey_reg    <= abs32(ey_reg);
            apx_reg    <= abs32(px);
            apy_reg    <= abs32(py);
            upd_reg    <= (px != '0) && (py != '0);
            rate_x_reg <= hit_reg ? mem_q_reg[95:64]  : '0;
            rate_y_reg <= hit_reg ? mem_q_reg[127:96] : '0;
        end

        if (cmd.diff)
        begin
            dneg_x_reg <= dx[VAL_W];
            dneg_y_reg <= dy[VAL_W];
            dmag_x_reg <= dx[VAL_W] ? (~dx[VAL_W-1:0] + 32'd1) : dx[VAL_W-1:0];
            dmag_y_reg <= dy[VAL_W] ? (~dy[VAL_W-1:0] + 32'd1) : dy[VAL_W-1:0];
            rmag_x_reg <= abs32(rate_x_reg);
            rmag_y_reg <= abs32(rate_y_reg);
        end

        // take the product issued in the previous step
        if (cmd.mul)
        begin
            case (cmd.step)
                STEP_RATE_Y:
                begin
                    if (upd_reg)
                    begin
                        rate_x_reg <= rate_sat(prod_q16, dneg_x_reg);
                        rmag_x_reg <= rate_mag(prod_q16, dneg_x_reg);
                    end
                end
                STEP_SPRING_X:
                begin
                    if (upd_reg)
                    begin
                        rate_y_reg <= rate_sat(prod_q16, dneg_y_reg);
                        rmag_y_reg <= rate_mag(prod_q16, dneg_y_reg);
                    end
                end
                STEP_SPRING_Y:
                begin
                    spring_x_reg <= ex_reg[31] ? -$signed({1'b0, prod_q16})
                                               :  $signed({1'b0, prod_q16});
                end
                STEP_DAMP_X:
                begin
                    spring_y_reg <= ey_reg[31] ? -$signed({1'b0, prod_q16})
                                               :  $signed({1'b0, prod_q16});
                end
                STEP_DAMP_Y:
                begin
                    damp_x_reg <= rate_x_reg[31] ? -$signed({1'b0, prod_q16})
                                                 :  $signed({1'b0, prod_q16});
                end
                STEP_SQ_X:
                begin
                    damp_y_reg <= rate_y_reg[31] ? -$signed({1'b0, prod_q16})
                                                 :  $signed({1'b0, prod_q16});
                end
                STEP_SQ_Y:
                begin
                    sq_x_reg  <= prod;
                    sum_x_reg <= {spring_x_reg[48], spring_x_reg}
                               + {damp_x_reg[48], damp_x_reg};
                    sum_y_reg <= {spring_y_reg[48], spring_y_reg}
                               + {damp_y_reg[48], damp_y_reg};
                end
                STEP_ENLO_X:
                begin
                    sq_y_reg    <= prod;
                    force_x_reg <= force_sat(sum_x_reg, ox_reg);
                    force_y_reg <= force_sat(sum_y_reg, oy_reg);
                end
                STEP_ENHI_X:
                begin
                    lo_reg <= prod;
                end
                STEP_ENLO_Y:
                begin
                    hi_x_reg <= prod + {32'd0, lo_reg[63:32]};
                end
                STEP_ENHI_Y:
                begin
                    lo_reg <= prod;
                end
                STEP_DONE:
                begin
                    hi_y_reg <= prod + {32'd0, lo_reg[63:32]};
                end
                default:
                begin
                end
            endcase
        end

        if (cmd.out_load)
        begin
            out_idx_reg <= idx_reg;
            out_fx_reg  <= force_x_reg;
            out_fy_reg  <= force_y_reg;
            out_ex_reg  <= energy_sat(hi_x_reg);
            out_ey_reg  <= energy_sat(hi_y_reg);
        end
    end

    assign robot_echo = out_idx_reg;
    assign force_x    = out_fx_reg;
    assign force_y    = out_fy_reg;
    assign energy_x   = out_ex_reg;
    assign energy_y   = out_ey_reg;

endmodule

// ===== hw/rtl/virtual_spring_damper_force.sv =====
// Virtual spring-damper force, top level: stream ports and configuration port.
// Depends on vsdf_pkg, vsdf_ctrl, vsdf_dpath (and vsdf_mul below it).
//
// Use:
//   One input word on s_* carries a robot index, its x/y offset from the
//   virtual leader and its formation rest offsets. One result word per input
//   leaves on m_*: the index echoed, the saturated force and energy per axis.
//   Per-robot stretch and rate history is kept in a small state memory.
//   cfg_* writes spring gain (0), damper gain (1) and sample rate (2); other
//   indexes are dropped. cfg_ready is always high; write only while idle.
// Sequence:
//   One item at a time. After acceptance an item passes three set-up states
//   (stretch and memory read, magnitudes, difference), thirteen steps of the
//   single shared 32x32 multiplier that forms all twelve products, and a
//   write-back state that loads the result register; the next input is
//   taken only after that, back in idle.
// Reset:
//   rst_n clears the sequencer, the output valid flag and every robot's
//   history; gains return to 1.0 and the sample rate to 20.0.
// Stall:
//   The result register frees the pipeline: the next item is accepted and
//   worked on while a word waits; the block holds before write-back if the
//   receiver has still not taken the previous word.
module virtual_spring_damper_force import vsdf_pkg::*;
#(
    parameter int MAX_ROBOTS = MAX_ROBOTS_DEF
)
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 s_tvalid,
    output logic                 s_tready,
    // robot_index [3:0], offset_x [35:4], offset_y [67:36], rest_x [99:68],
    // rest_y [131:100], zero padding [135:132]
    input  logic [TDATA_W-1:0]   s_tdata,
    output logic                 m_tvalid,
    input  logic                 m_tready,
    // robot_echo [3:0], force_x [35:4], force_y [67:36], energy_x [99:68],
    // energy_y [131:100], zero padding [135:132]
    output logic [TDATA_W-1:0]   m_tdata,
    input  logic                 cfg_valid,
    output logic                 cfg_ready,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [VAL_W-1:0]     cfg_data
);

    vsdf_cmd_t        cmd;
    logic [IDX_W-1:0] robot_echo;
    logic [VAL_W-1:0] force_x, force_y, energy_x, energy_y;

    // registers accept a write in any cycle
    assign cfg_ready = 1'b1;

    vsdf_ctrl u_ctrl
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .cmd      (cmd)
    );

    vsdf_dpath #(
        .MAX_ROBOTS (MAX_ROBOTS)
    ) u_dpath
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .cmd         (cmd),
        .cfg_valid   (cfg_valid),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data),
        .robot_index (s_tdata[3:0]),
        .offset_x    (s_tdata[35:4]),
        .offset_y    (s_tdata[67:36]),
        .rest_x      (s_tdata[99:68]),
        .rest_y      (s_tdata[131:100]),
        .robot_echo  (robot_echo),
        .force_x     (force_x),
        .force_y     (force_y),
        .energy_x    (energy_x),
        .energy_y    (energy_y)
    );

    assign m_tdata = {4'd0, energy_y, energy_x, force_y, force_x, robot_echo};

endmodule

// ===== hw/rtl/vsdf_checker.sv =====
// Port-level checks for the spring-damper block, bound to its top level.
// Depends on vsdf_pkg and virtual_spring_damper_force_macros.svh.
`include "virtual_spring_damper_force_macros.svh"

module vsdf_checker import vsdf_pkg::*;
(
    input logic               clk,
    input logic               rst_n,
    input logic               s_tvalid,
    input logic               s_tready,
    input logic               m_tvalid,
    input logic               m_tready,
    input logic [TDATA_W-1:0] m_tdata
);

    // items accepted but not yet delivered
    logic [1:0] pend_reg, pend_next;

    always_comb
    begin
        pend_next = pend_reg;
        if ((s_tvalid && s_tready) && !(m_tvalid && m_tready))
            pend_next = pend_reg + 2'd1;
        else if (!(s_tvalid && s_tready) && (m_tvalid && m_tready))
            pend_next = pend_reg - 2'd1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            pend_reg <= '0;
        else
            pend_reg <= pend_next;
    end

    `VSDF_ASSERT_NEXT(a_out_hold, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata), "result word changed while stalled")
    `VSDF_ASSERT_NEXT(a_one_in_flight, s_tvalid && s_tready, !s_tready, "input taken again in the cycle after acceptance")
    `VSDF_ASSERT_IMP(a_no_invented, m_tvalid, pend_reg != 2'd0, "result word offered with no item outstanding")
    `VSDF_ASSERT(a_pend_bound, pend_reg <= 2'd2, "more than two items outstanding")

endmodule

bind virtual_spring_damper_force vsdf_checker u_vsdf_checker
(
    .clk      (clk),
    .rst_n    (rst_n),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);
